// ===== design/dbt_pkg.sv =====
// Shared types, constants and register codes for the button debounce tap-hold detector.
package dbt_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int NOW_W      = 32;
  localparam int CFG_TIME_W = 16;
  localparam int TAPS_W     = 4;
  localparam int CNT_W      = 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [CNT_W-1:0] TAP_MAX = '1;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_TAPS     = 2'd2;
  localparam logic [1:0] REG_HOLD     = 2'd3;

  localparam logic [CFG_TIME_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_TIME_W-1:0] TIMEOUT_RST  = 16'd500;
  localparam logic [TAPS_W-1:0]     TAPS_RST     = 4'd3;
  localparam logic [CFG_TIME_W-1:0] HOLD_RST     = 16'd1000;

  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] debounce;
    logic [CFG_TIME_W-1:0] timeout;
    logic [TAPS_W-1:0]     taps;
    logic [CFG_TIME_W-1:0] hold;
  } cfg_t;

  typedef struct packed {
    logic             pressed;
    time_t            last_press;
    time_t            last_release;
    time_t            last_tap;
    logic [CNT_W-1:0] tap_cnt;
    logic             hold_armed;
    logic             action;
  } state_t;

  typedef struct packed {
    logic  pin_level;
    time_t now;
    logic  clear_action;
  } item_t;

  typedef struct packed {
    logic             is_pressed;
    logic             press_edge;
    logic             release_edge;
    logic             action_pending;
    logic [CNT_W-1:0] taps_seen;
  } result_t;

endpackage

// ===== design/dbt_if.sv =====
// Valid-ready channel interfaces for input items and result items.
interface dbt_in_if import dbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pin_level;
  logic [NOW_W-1:0] now_ms;
  logic             clear_action;

  modport source (output valid, pin_level, now_ms, clear_action, input ready);
  modport sink (input valid, pin_level, now_ms, clear_action, output ready);
endinterface

interface dbt_out_if import dbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_pressed;
  logic             press_edge;
  logic             release_edge;
  logic             action_pending;
  logic [CNT_W-1:0] taps_seen;

  modport source (output valid, is_pressed, press_edge, release_edge, action_pending,
                  taps_seen, input ready);
  modport sink (input valid, is_pressed, press_edge, release_edge, action_pending,
                taps_seen, output ready);
endinterface

// ===== design/dbt_gesture.sv =====
// Next-state and result logic for one update of the debounce and tap-hold detector.
module dbt_gesture import dbt_pkg::*; (
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res
);

  time_t            d_press;
  time_t            d_release;
  time_t            d_tap_old;
  time_t            d_tap_new;
  time_t            debounce_w;
  time_t            timeout_w;
  time_t            hold_w;
  logic             rise;
  logic             fall;
  logic             fire;
  logic             pressed;
  logic [CNT_W-1:0] cnt_inc;

  assign debounce_w = time_t'(cfg.debounce);
  assign timeout_w  = time_t'(cfg.timeout);
  assign hold_w     = time_t'(cfg.hold);

  assign d_press   = item.now - st.last_press;
  assign d_release = item.now - st.last_release;
  assign d_tap_old = item.now - st.last_tap;

  assign rise = item.pin_level && !st.pressed && (d_press > debounce_w);
  assign fall = !item.pin_level && st.pressed && (d_release > debounce_w);
  assign pressed = rise ? 1'b1 : (fall ? 1'b0 : st.pressed);
  assign d_tap_new = rise ? '0 : d_tap_old;
  assign cnt_inc = (st.tap_cnt == TAP_MAX) ? st.tap_cnt : st.tap_cnt + 1'b1;

  always_comb begin
    st_nxt = st;
    st_nxt.pressed = pressed;
    fire = 1'b0;
    if (rise) begin
      st_nxt.last_press = item.now;
      st_nxt.last_tap   = item.now;
      if (d_tap_old <= timeout_w) begin
        st_nxt.tap_cnt = cnt_inc;
        if (cnt_inc >= {{(CNT_W-TAPS_W){1'b0}}, cfg.taps}) begin
          st_nxt.hold_armed = 1'b1;
        end
      end else begin
        st_nxt.tap_cnt = CNT_W'(1);
      end
    end
    if (fall) begin
      st_nxt.last_release = item.now;
    end
    if (st_nxt.hold_armed && pressed && (d_tap_new >= hold_w)) begin
      fire = 1'b1;
      st_nxt.hold_armed = 1'b0;
      st_nxt.tap_cnt = '0;
    end
    if (!pressed) begin
      st_nxt.hold_armed = 1'b0;
      if (d_tap_new > timeout_w) begin
        st_nxt.tap_cnt = '0;
      end
    end
    st_nxt.action = (st.action && !item.clear_action) || fire;
  end

  assign res.is_pressed     = pressed;
  assign res.press_edge     = rise;
  assign res.release_edge   = fall;
  assign res.action_pending = st_nxt.action;
  assign res.taps_seen      = st_nxt.tap_cnt;

endmodule

// ===== design/button_debounce_tap_hold_detector_unit.sv =====
// Top level: input register, update logic, result register and configuration registers.
// An accepted item is held in the input register; its result is written to the result register when it advances.
// Throughput: one item per cycle while the output is not stalled; the update runs in the cycle between the input
// register and the result register, and state is written at the same edge.
// Stall: a held result keeps one item in the input register before input ready drops.
// Reset: synchronous active-low rst_n clears state, valid bits and config to defaults.
module button_debounce_tap_hold_detector_unit import dbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dbt_in_if.sink            in_ch,
  dbt_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   item_r;
  item_t   item_in;
  result_t res_r;
  result_t res_nxt;
  logic    in_valid_r;
  logic    out_valid_r;
  logic    advance;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= DEBOUNCE_RST;
      cfg_r.timeout  <= TIMEOUT_RST;
      cfg_r.taps     <= TAPS_RST;
      cfg_r.hold     <= HOLD_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DEBOUNCE: cfg_r.debounce <= pwdata[CFG_TIME_W-1:0];
        REG_TIMEOUT:  cfg_r.timeout  <= pwdata[CFG_TIME_W-1:0];
        REG_TAPS:     cfg_r.taps     <= pwdata[TAPS_W-1:0];
        REG_HOLD:     cfg_r.hold     <= pwdata[CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEBOUNCE: prdata = DATA_W'(cfg_r.debounce);
      REG_TIMEOUT:  prdata = DATA_W'(cfg_r.timeout);
      REG_TAPS:     prdata = DATA_W'(cfg_r.taps);
      REG_HOLD:     prdata = DATA_W'(cfg_r.hold);
      default:      prdata = '0;
    endcase
  end

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  assign item_in.pin_level    = in_ch.pin_level;
  assign item_in.now          = in_ch.now_ms[TIME_WIDTH-1:0];
  assign item_in.clear_action = in_ch.clear_action;

  dbt_gesture u_gesture (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_in;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_pressed     = res_r.is_pressed;
  assign out_ch.press_edge     = res_r.press_edge;
  assign out_ch.release_edge   = res_r.release_edge;
  assign out_ch.action_pending = res_r.action_pending;
  assign out_ch.taps_seen      = res_r.taps_seen;

  a_edges_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.press_edge && res_r.release_edge))
    else $error("press and release edge in one item");

  a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.press_edge || res_r.release_edge) |->
      res_r.is_pressed == res_r.press_edge)
    else $error("edge disagrees with pressed state");

  a_armed_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hold_armed |-> st_r.pressed)
    else $error("hold armed while released");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r))
    else $error("stalled item lost");

endmodule
